// ----- hdl/capacitated_line_assignment_dp_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the capacitated line assignment block
// Shared helpers that wrap clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef CAPACITATED_LINE_ASSIGNMENT_DP_DEFINES_SVH
`define CAPACITATED_LINE_ASSIGNMENT_DP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CLA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CLA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/cla_pkg.sv -----
// ----------------------------------------------------------------------------
// cla_pkg
// Shared constants and the command and status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package cla_pkg;

    // Default sizes of the stores and the coordinate width.
    localparam int MAX_ROBOTS_DEF    = 128;
    localparam int MAX_FACTORIES_DEF = 128;
    localparam int POS_WIDTH_DEF     = 32;

    // Fixed widths of the channel fields.
    localparam int POS_IN_W   = 32;
    localparam int CAP_IN_W   = 8;
    localparam int DIST_OUT_W = 39;

    // Item kinds.
    localparam logic REQ_ROBOT   = 1'b0;
    localparam logic REQ_FACTORY = 1'b1;

    // Commands from the controller, one strobe per datapath action.
    typedef struct packed {
        logic load_item;
        logic drop;
        logic ins_init;
        logic ins_rd;
        logic ins_shift;
        logic ins_put;
        logic row_wr;
        logic f_rd;
        logic f_get;
        logic f_inc;
        logic j_rd;
        logic j_get;
        logic k_rd;
        logic k_dist;
        logic k_sum;
        logic k_cmp;
        logic j_wr;
        logic res_rd;
        logic res_get;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic item_type;
        logic item_last;
        logic full;
        logic ins_zero;
        logic ins_greater;
        logic row_last;
        logic f_done;
        logic t_zero;
        logic lim_zero;
        logic k_last;
        logic out_free;
    } status_t;

endpackage

// ----- hdl/cla_if.sv -----
// ----------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for input items and for results; a transfer occurs
// on a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface cla_item_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic signed [cla_pkg::POS_IN_W-1:0] position;
    logic        [cla_pkg::CAP_IN_W-1:0] capacity;
    logic                                last;

    modport source (output valid, req_type, position, capacity, last, input ready);
    modport sink   (input valid, req_type, position, capacity, last, output ready);
endinterface

interface cla_result_if;
    logic                              valid;
    logic                              ready;
    logic [cla_pkg::DIST_OUT_W-1:0]    min_distance;
    logic                              infeasible;
    logic                              dropped;

    modport source (output valid, min_distance, infeasible, dropped, input ready);
    modport sink   (input valid, min_distance, infeasible, dropped, output ready);
endinterface

// ----- hdl/cla_ctrl.sv -----
// ----------------------------------------------------------------------------
// cla_ctrl
// Sequencer for loading, sorted insertion, the cost-row sweep and the
// result transfer. Issues one command bundle per cycle to the datapath.
// ----------------------------------------------------------------------------
module cla_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  cla_pkg::status_t status,
    output cla_pkg::cmd_t    cmd
);

    typedef enum logic [16:0] {
        S_IDLE     = 17'b00000000000000001,
        S_LOAD     = 17'b00000000000000010,
        S_INS_RD   = 17'b00000000000000100,
        S_INS_CMP  = 17'b00000000000001000,
        S_INS_PUT  = 17'b00000000000010000,
        S_ROW_INIT = 17'b00000000000100000,
        S_F_CHK    = 17'b00000000001000000,
        S_F_GET    = 17'b00000000010000000,
        S_J_CHK    = 17'b00000000100000000,
        S_J_GET    = 17'b00000001000000000,
        S_K_RD     = 17'b00000010000000000,
        S_K_DIST   = 17'b00000100000000000,
        S_K_SUM    = 17'b00001000000000000,
        S_K_CMP    = 17'b00010000000000000,
        S_J_WR     = 17'b00100000000000000,
        S_RES_RD   = 17'b01000000000000000,
        S_RES_GET  = 17'b10000000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_ready = (state_reg == S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (status.full)
                begin
                    cmd.drop   = 1'b1;
                    state_next = status.item_last ? S_ROW_INIT : S_IDLE;
                end
                else
                begin
                    cmd.ins_init = 1'b1;
                    state_next   = S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                if (status.ins_zero)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    cmd.ins_rd = 1'b1;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (status.ins_greater)
                begin
                    cmd.ins_shift = 1'b1;
                    state_next    = S_INS_RD;
                end
                else
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT:
            begin
                cmd.ins_put = 1'b1;
                state_next  = status.item_last ? S_ROW_INIT : S_IDLE;
            end
            S_ROW_INIT:
            begin
                cmd.row_wr = 1'b1;
                if (status.row_last)
                begin
                    state_next = S_F_CHK;
                end
            end
            S_F_CHK:
            begin
                if (status.f_done)
                begin
                    state_next = S_RES_RD;
                end
                else
                begin
                    cmd.f_rd   = 1'b1;
                    state_next = S_F_GET;
                end
            end
            S_F_GET:
            begin
                cmd.f_get  = 1'b1;
                state_next = S_J_CHK;
            end
            S_J_CHK:
            begin
                if (status.t_zero)
                begin
                    cmd.f_inc  = 1'b1;
                    state_next = S_F_CHK;
                end
                else
                begin
                    cmd.j_rd   = 1'b1;
                    state_next = S_J_GET;
                end
            end
            S_J_GET:
            begin
                cmd.j_get  = 1'b1;
                state_next = status.lim_zero ? S_J_WR : S_K_RD;
            end
            S_K_RD:
            begin
                cmd.k_rd   = 1'b1;
                state_next = S_K_DIST;
            end
            S_K_DIST:
            begin
                cmd.k_dist = 1'b1;
                state_next = S_K_SUM;
            end
            S_K_SUM:
            begin
                cmd.k_sum  = 1'b1;
                state_next = S_K_CMP;
            end
            S_K_CMP:
            begin
                cmd.k_cmp  = 1'b1;
                state_next = status.k_last ? S_J_WR : S_K_RD;
            end
            S_J_WR:
            begin
                cmd.j_wr   = 1'b1;
                state_next = S_J_CHK;
            end
            S_RES_RD:
            begin
                cmd.res_rd = 1'b1;
                state_next = S_RES_GET;
            end
            S_RES_GET:
            begin
                if (status.out_free)
                begin
                    cmd.res_get = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/cla_datapath.sv -----
// ----------------------------------------------------------------------------
// cla_datapath
// Robot, factory and cost-row memories with their counters, the insertion
// compare, the distance and cost arithmetic, and the result register.
// ----------------------------------------------------------------------------
`include "capacitated_line_assignment_dp_defines.svh"

module cla_datapath #(
    parameter int MAX_ROBOTS    = cla_pkg::MAX_ROBOTS_DEF,
    parameter int MAX_FACTORIES = cla_pkg::MAX_FACTORIES_DEF,
    parameter int POS_WIDTH     = cla_pkg::POS_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cla_pkg::cmd_t                       cmd,
    output cla_pkg::status_t                    status,
    input  logic                                in_req_type,
    input  logic signed [cla_pkg::POS_IN_W-1:0] in_position,
    input  logic        [cla_pkg::CAP_IN_W-1:0] in_capacity,
    input  logic                                in_last,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic [cla_pkg::DIST_OUT_W-1:0]      res_min_distance,
    output logic                                res_infeasible,
    output logic                                res_dropped
);

    // Index and count widths.
    localparam int RIW = (MAX_ROBOTS > 1) ? $clog2(MAX_ROBOTS) : 1;
    localparam int FIW = (MAX_FACTORIES > 1) ? $clog2(MAX_FACTORIES) : 1;
    localparam int RCW = $clog2(MAX_ROBOTS + 1);
    localparam int FCW = $clog2(MAX_FACTORIES + 1);
    localparam int IW  = (RCW > FCW) ? RCW : FCW;
    localparam int CW  = POS_WIDTH + RCW;

    // Memories.
    logic signed [POS_WIDTH-1:0] robot_mem [MAX_ROBOTS];
    logic signed [POS_WIDTH-1:0] fpos_mem  [MAX_FACTORIES];
    logic        [RCW-1:0]       fcap_mem  [MAX_FACTORIES];
    logic        [CW:0]          cost_mem  [MAX_ROBOTS + 1];

    logic signed [POS_WIDTH-1:0] robot_rdata;
    logic signed [POS_WIDTH-1:0] fpos_rdata;
    logic        [RCW-1:0]       fcap_rdata;
    logic        [CW:0]          cost_rdata;

    // Control and working registers.
    logic [RCW-1:0] robot_cnt_reg;
    logic [FCW-1:0] fact_cnt_reg;
    logic           drop_reg;
    logic           type_reg;
    logic           last_reg;
    logic signed [POS_WIDTH-1:0] pos_reg;
    logic [RCW-1:0] cap_reg;
    logic [IW-1:0]  ins_reg;
    logic [RCW-1:0] rc_reg;
    logic [FCW-1:0] f_reg;
    logic [RCW-1:0] t_reg;
    logic [RCW-1:0] k_reg;
    logic [RCW-1:0] lim_reg;
    logic signed [POS_WIDTH-1:0] fp_reg;
    logic [RCW-1:0] fcap_reg;
    logic [POS_WIDTH-1:0] dist_reg;
    logic [CW-1:0]  sum_reg;
    logic [CW:0]    cval_reg;
    logic [CW:0]    best_reg;
    logic           out_valid_reg;
    logic [cla_pkg::DIST_OUT_W-1:0] out_dist_reg;
    logic           out_inf_reg;
    logic           out_drop_reg;

    // Combinational helpers.
    logic [31:0]                 cap_ext;
    logic [RCW-1:0]              cap_sat;
    logic signed [POS_WIDTH-1:0] pos_in;
    logic [IW-1:0]               ins_prev;
    logic [RCW-1:0]              tk_idx;
    logic [RCW-1:0]              lim_val;
    logic [RCW-1:0]              cost_raddr;
    logic [IW-1:0]               robot_raddr;
    logic [IW-1:0]               fact_raddr;
    logic signed [POS_WIDTH:0]   diff;
    logic [POS_WIDTH:0]          mag;
    logic [CW-1:0]               cand;
    logic                        robot_greater;
    logic                        fact_greater;

    // Input conversion: saturate capacity, size the coordinate.
    assign cap_ext = 32'(in_capacity);
    assign cap_sat = (cap_ext > 32'(MAX_ROBOTS)) ? RCW'(MAX_ROBOTS) : RCW'(cap_ext);
    assign pos_in  = POS_WIDTH'(in_position);

    assign ins_prev = ins_reg - 1'b1;
    assign tk_idx   = t_reg - k_reg;
    assign lim_val  = (fcap_reg < t_reg) ? fcap_reg : t_reg;

    // Read address selection.
    always_comb
    begin
        robot_raddr = cmd.k_rd ? IW'(tk_idx) : ins_prev;
        fact_raddr  = cmd.f_rd ? IW'(f_reg) : ins_prev;
        if (cmd.j_rd)
        begin
            cost_raddr = t_reg;
        end
        else if (cmd.k_rd)
        begin
            cost_raddr = tk_idx;
        end
        else
        begin
            cost_raddr = robot_cnt_reg;
        end
    end

    // Robot memory.
    always_ff @(posedge clk)
    begin
        if ((cmd.ins_shift || cmd.ins_put) && (type_reg == cla_pkg::REQ_ROBOT))
        begin
            robot_mem[ins_reg[RIW-1:0]] <= cmd.ins_shift ? robot_rdata : pos_reg;
        end
        if (cmd.ins_rd || cmd.k_rd)
        begin
            robot_rdata <= robot_mem[robot_raddr[RIW-1:0]];
        end
    end

    // Factory memories.
    always_ff @(posedge clk)
    begin
        if ((cmd.ins_shift || cmd.ins_put) && (type_reg == cla_pkg::REQ_FACTORY))
        begin
            fpos_mem[ins_reg[FIW-1:0]] <= cmd.ins_shift ? fpos_rdata : pos_reg;
            fcap_mem[ins_reg[FIW-1:0]] <= cmd.ins_shift ? fcap_rdata : cap_reg;
        end
        if (cmd.ins_rd || cmd.f_rd)
        begin
            fpos_rdata <= fpos_mem[fact_raddr[FIW-1:0]];
            fcap_rdata <= fcap_mem[fact_raddr[FIW-1:0]];
        end
    end

    // Cost row memory; the top bit marks an unreachable cost.
    always_ff @(posedge clk)
    begin
        if (cmd.row_wr)
        begin
            cost_mem[rc_reg] <= (rc_reg == '0) ? '0 : {1'b1, CW'(0)};
        end
        else if (cmd.j_wr)
        begin
            cost_mem[t_reg] <= best_reg;
        end
        if (cmd.j_rd || cmd.k_rd || cmd.res_rd)
        begin
            cost_rdata <= cost_mem[cost_raddr];
        end
    end

    // Counters and drop flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            robot_cnt_reg <= '0;
            fact_cnt_reg  <= '0;
            drop_reg      <= 1'b0;
        end
        else if (cmd.res_get)
        begin
            robot_cnt_reg <= '0;
            fact_cnt_reg  <= '0;
            drop_reg      <= 1'b0;
        end
        else if (cmd.drop)
        begin
            drop_reg <= 1'b1;
        end
        else if (cmd.ins_put)
        begin
            if (type_reg == cla_pkg::REQ_ROBOT)
            begin
                robot_cnt_reg <= robot_cnt_reg + 1'b1;
            end
            else
            begin
                fact_cnt_reg <= fact_cnt_reg + 1'b1;
            end
        end
    end

    // Captured item and insertion index.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            type_reg <= in_req_type;
            last_reg <= in_last;
            pos_reg  <= pos_in;
            cap_reg  <= cap_sat;
            rc_reg   <= '0;
        end
        if (cmd.ins_init)
        begin
            ins_reg <= (type_reg == cla_pkg::REQ_ROBOT) ? IW'(robot_cnt_reg) : IW'(fact_cnt_reg);
        end
        else if (cmd.ins_shift)
        begin
            ins_reg <= ins_prev;
        end
        if (cmd.row_wr)
        begin
            rc_reg <= rc_reg + 1'b1;
        end
    end

    // Table sweep indices and factory operands.
    always_ff @(posedge clk)
    begin
        if (cmd.row_wr)
        begin
            f_reg <= '0;
        end
        else if (cmd.f_inc)
        begin
            f_reg <= f_reg + 1'b1;
        end
        if (cmd.f_get)
        begin
            fp_reg   <= fpos_rdata;
            fcap_reg <= fcap_rdata;
            t_reg    <= robot_cnt_reg;
        end
        else if (cmd.j_wr)
        begin
            t_reg <= t_reg - 1'b1;
        end
        if (cmd.j_get)
        begin
            k_reg   <= RCW'(1);
            lim_reg <= lim_val;
        end
        else if (cmd.k_cmp)
        begin
            k_reg <= k_reg + 1'b1;
        end
    end

    // Distance between a robot and the current factory.
    assign diff = {robot_rdata[POS_WIDTH-1], robot_rdata} - {fp_reg[POS_WIDTH-1], fp_reg};
    assign mag  = diff[POS_WIDTH] ? (~diff + 1'b1) : diff;
    assign cand = cval_reg[CW-1:0] + sum_reg;

    // Running sum and best cost for one row entry.
    always_ff @(posedge clk)
    begin
        if (cmd.j_get)
        begin
            best_reg <= cost_rdata;
            sum_reg  <= '0;
        end
        if (cmd.k_dist)
        begin
            dist_reg <= mag[POS_WIDTH-1:0];
            cval_reg <= cost_rdata;
        end
        if (cmd.k_sum)
        begin
            sum_reg <= sum_reg + CW'(dist_reg);
        end
        if (cmd.k_cmp && !cval_reg[CW] && (best_reg[CW] || (cand < best_reg[CW-1:0])))
        begin
            best_reg <= {1'b0, cand};
        end
    end

    // Result register, freed by the output transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_get)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_get)
        begin
            out_inf_reg  <= cost_rdata[CW];
            out_dist_reg <= cost_rdata[CW] ? '0 : cla_pkg::DIST_OUT_W'(cost_rdata[CW-1:0]);
            out_drop_reg <= drop_reg;
        end
    end

    assign res_valid        = out_valid_reg;
    assign res_min_distance = out_dist_reg;
    assign res_infeasible   = out_inf_reg;
    assign res_dropped      = out_drop_reg;

    // Insertion compares: factories order by position, then by capacity.
    assign robot_greater = robot_rdata > pos_reg;
    assign fact_greater  = (fpos_rdata > pos_reg) ||
                           ((fpos_rdata == pos_reg) && (fcap_rdata > cap_reg));

    // Status to the controller.
    always_comb
    begin
        status.item_type   = type_reg;
        status.item_last   = last_reg;
        status.full        = (type_reg == cla_pkg::REQ_ROBOT) ?
                             (robot_cnt_reg == RCW'(MAX_ROBOTS)) :
                             (fact_cnt_reg == FCW'(MAX_FACTORIES));
        status.ins_zero    = (ins_reg == '0);
        status.ins_greater = (type_reg == cla_pkg::REQ_ROBOT) ? robot_greater : fact_greater;
        status.row_last    = (rc_reg == robot_cnt_reg);
        status.f_done      = (f_reg == fact_cnt_reg);
        status.t_zero      = (t_reg == '0);
        status.lim_zero    = (lim_val == '0);
        status.k_last      = (k_reg == lim_reg);
        status.out_free    = !out_valid_reg || res_ready;
    end

    // Checks.
    `CLA_ASSERT_IMP(a_robot_cnt_bound, 1'b1, robot_cnt_reg <= RCW'(MAX_ROBOTS), "robot count overflow")
    `CLA_ASSERT_IMP(a_k_range, cmd.k_cmp, (k_reg != '0) && (k_reg <= lim_reg), "run length out of range")
    `CLA_ASSERT_NXT(a_set_cleared, cmd.res_get, (robot_cnt_reg == '0) && (fact_cnt_reg == '0) && !drop_reg, "set not cleared after result")
    `CLA_ASSERT_IMP(a_inf_zero, out_valid_reg && out_inf_reg, out_dist_reg == '0, "infeasible result carries a distance")

endmodule

// ----- hdl/capacitated_line_assignment_dp.sv -----
// ----------------------------------------------------------------------------
// capacitated_line_assignment_dp
// Minimum-cost assignment of robots to capacitated factories on a line.
// ----------------------------------------------------------------------------
// Robot and factory items are loaded one per transfer and kept sorted by
// insertion; a load compares the new item against the stored entries from
// the back, one single-port memory read and compare each, shifting larger
// entries up until it finds its place or reaches the front.
// An item marked last then runs the table on the cost row: it initialises
// the row's m + 1 entries, and for each factory, for each row entry t, it
// sums a run of min(capacity, t) robots through the single read port of
// the cost row and the four-step inner accumulate (read, distance, sum,
// compare); the result is then read from the cost row and handed to the
// output register. Loads into a full store are discarded and reported with
// the result. The next item is taken while a result still waits there.
// ----------------------------------------------------------------------------
module capacitated_line_assignment_dp #(
    parameter int MAX_ROBOTS    = cla_pkg::MAX_ROBOTS_DEF,
    parameter int MAX_FACTORIES = cla_pkg::MAX_FACTORIES_DEF,
    parameter int POS_WIDTH     = cla_pkg::POS_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    cla_item_if.sink      item,
    cla_result_if.source  result
);

    cla_pkg::cmd_t    cmd;
    cla_pkg::status_t status;
    logic             in_ready;

    assign item.ready = in_ready;

    // Sequencer.
    cla_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (in_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Stores and arithmetic.
    cla_datapath #(
        .MAX_ROBOTS    (MAX_ROBOTS),
        .MAX_FACTORIES (MAX_FACTORIES),
        .POS_WIDTH     (POS_WIDTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_req_type      (item.req_type),
        .in_position      (item.position),
        .in_capacity      (item.capacity),
        .in_last          (item.last),
        .res_valid        (result.valid),
        .res_ready        (result.ready),
        .res_min_distance (result.min_distance),
        .res_infeasible   (result.infeasible),
        .res_dropped      (result.dropped)
    );

endmodule
